// ----- rtl/core/amf0_pkg.sv -----
// Shared types and constants for the AMF0 token serializer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amf0_pkg;

  // token actions
  localparam logic [3:0] ACT_NUMBER      = 4'd0;
  localparam logic [3:0] ACT_BOOLEAN     = 4'd1;
  localparam logic [3:0] ACT_STRING_HDR  = 4'd2;
  localparam logic [3:0] ACT_OBJ_OPEN    = 4'd3;
  localparam logic [3:0] ACT_OBJ_CLOSE   = 4'd4;
  localparam logic [3:0] ACT_ARR_OPEN    = 4'd5;
  localparam logic [3:0] ACT_ARR_CLOSE   = 4'd6;
  localparam logic [3:0] ACT_NULL        = 4'd7;
  localparam logic [3:0] ACT_STRING_BYTE = 4'd8;
  localparam logic [3:0] ACT_FINISH      = 4'd9;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // type markers
  localparam logic [7:0] TAG_NUMBER      = 8'h00;
  localparam logic [7:0] TAG_BOOLEAN     = 8'h01;
  localparam logic [7:0] TAG_STRING      = 8'h02;
  localparam logic [7:0] TAG_OBJECT      = 8'h03;
  localparam logic [7:0] TAG_NULL        = 8'h05;
  localparam logic [7:0] TAG_ECMA_ARRAY  = 8'h08;
  localparam logic [7:0] TAG_OBJECT_END  = 8'h09;
  localparam logic [7:0] TAG_LONG_STRING = 8'h0c;

  // configuration register indexes
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_START_FILL = 1'b1;

  localparam logic [31:0] CAPACITY_RESET   = 32'd4096;
  localparam logic [31:0] START_FILL_RESET = 32'd0;

  // encoded token: up to nine bytes, first byte in the top bits
  localparam int CMD_BYTES = 9;
  localparam int CMD_BITS  = 8 * CMD_BYTES;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = 2;

  typedef struct packed {
    logic [3:0]          n;      // bytes to emit, 0 for a status-only item
    logic [CMD_BITS-1:0] bytes;
    logic [1:0]          status;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/amf0_front.sv -----
// Front end: configuration registers, grammar and capacity checks, token encoding.
// Depends on amf0_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amf0_front #(
  parameter int MAX_NESTING = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              accept_i,
  input  wire logic [3:0]        action_i,
  input  wire logic [63:0]       value_i,
  output amf0_pkg::cmd_t         cmd_o
);

  localparam int DW = $clog2(MAX_NESTING + 1);

  logic [31:0]   cap_q, start_q;
  logic [DW-1:0] obj_q, obj_d, arr_q, arr_d;
  logic          key_q, key_d;
  logic [31:0]   fill_q, fill_d;
  logic [1:0]    sticky_q, sticky_d;
  logic [31:0]   body_q, body_d;

  logic [3:0]    hdr;
  logic [31:0]   vlen;
  logic [33:0]   need;
  logic          room;
  logic          nested_now;
  logic [DW:0]   depth_sum;

  always_comb begin
    hdr  = 4'd0;
    vlen = '0;
    case (action_i)
      amf0_pkg::ACT_NUMBER:     hdr = 4'd9;
      amf0_pkg::ACT_BOOLEAN:    hdr = 4'd2;
      amf0_pkg::ACT_STRING_HDR: begin
        vlen = value_i[31:0];
        if (key_q) begin
          hdr = 4'd2;
        end else if (value_i[31:16] == '0) begin
          hdr = 4'd3;
        end else begin
          hdr = 4'd5;
        end
      end
      amf0_pkg::ACT_OBJ_OPEN:   hdr = 4'd1;
      amf0_pkg::ACT_NULL:       hdr = 4'd1;
      amf0_pkg::ACT_ARR_OPEN:   hdr = 4'd5;
      amf0_pkg::ACT_OBJ_CLOSE:  hdr = 4'd3;
      amf0_pkg::ACT_ARR_CLOSE:  hdr = 4'd3;
      default:                  hdr = 4'd0;
    endcase
  end

  assign need       = {2'b00, fill_q} + {2'b00, vlen} + {30'd0, hdr};
  assign room       = need <= {2'b00, cap_q};
  assign nested_now = (obj_q != '0) || (arr_q != '0);
  assign depth_sum  = {1'b0, obj_q} + {1'b0, arr_q};

  always_comb begin
    logic [1:0]          err;
    logic                flag;
    logic [1:0]          flag_st;
    logic [3:0]          n;
    logic [71:0]         bytes;
    logic [DW-1:0]       nobj, narr;
    logic                nkey;
    logic [31:0]         nbody;

    obj_d    = obj_q;
    arr_d    = arr_q;
    key_d    = key_q;
    fill_d   = fill_q;
    sticky_d = sticky_q;
    body_d   = body_q;
    err      = amf0_pkg::ST_OK;
    flag     = 1'b0;
    flag_st  = amf0_pkg::ST_OK;
    n        = 4'd0;
    bytes    = '0;
    nobj     = obj_q;
    narr     = arr_q;
    nkey     = key_q;
    nbody    = body_q;

    if (action_i == amf0_pkg::ACT_FINISH) begin
      flag = 1'b1;
      if (sticky_q != amf0_pkg::ST_OK) begin
        flag_st = sticky_q;
      end else if (nested_now || (body_q != '0)) begin
        flag_st = amf0_pkg::ST_INVALID;
      end
      obj_d    = '0;
      arr_d    = '0;
      key_d    = 1'b0;
      fill_d   = start_q;
      sticky_d = amf0_pkg::ST_OK;
      body_d   = '0;
    end else if (sticky_q != amf0_pkg::ST_OK) begin
      flag    = 1'b1;
      flag_st = sticky_q;
    end else if (body_q != '0) begin
      if (action_i != amf0_pkg::ACT_STRING_BYTE) begin
        err = amf0_pkg::ST_INVALID;
      end else begin
        n     = 4'd1;
        bytes = {value_i[7:0], 64'd0};
        nbody = body_q - 32'd1;
      end
    end else begin
      case (action_i)
        amf0_pkg::ACT_NUMBER, amf0_pkg::ACT_BOOLEAN, amf0_pkg::ACT_NULL: begin
          if (key_q) begin
            err = amf0_pkg::ST_INVALID;
          end else if (!room) begin
            err = amf0_pkg::ST_NO_SPACE;
          end else begin
            nkey = nested_now;
            if (action_i == amf0_pkg::ACT_NUMBER) begin
              n     = 4'd9;
              bytes = {amf0_pkg::TAG_NUMBER, value_i};
            end else if (action_i == amf0_pkg::ACT_BOOLEAN) begin
              n     = 4'd2;
              bytes = {amf0_pkg::TAG_BOOLEAN, value_i[7:0], 56'd0};
            end else begin
              n     = 4'd1;
              bytes = {amf0_pkg::TAG_NULL, 64'd0};
            end
          end
        end
        amf0_pkg::ACT_STRING_HDR: begin
          if (key_q) begin
            if (value_i[63:16] != '0) begin
              err = amf0_pkg::ST_INVALID;
            end else if (!room) begin
              err = amf0_pkg::ST_NO_SPACE;
            end else begin
              n     = 4'd2;
              bytes = {value_i[15:0], 56'd0};
              nkey  = 1'b0;
              nbody = value_i[31:0];
            end
          end else if (value_i[63:32] != '0) begin
            err = amf0_pkg::ST_INVALID;
          end else if (!room) begin
            err = amf0_pkg::ST_NO_SPACE;
          end else begin
            nkey  = nested_now;
            nbody = value_i[31:0];
            if (value_i[31:16] == '0) begin
              n     = 4'd3;
              bytes = {amf0_pkg::TAG_STRING, value_i[15:0], 48'd0};
            end else begin
              n     = 4'd5;
              bytes = {amf0_pkg::TAG_LONG_STRING, value_i[31:0], 32'd0};
            end
          end
        end
        amf0_pkg::ACT_OBJ_OPEN, amf0_pkg::ACT_ARR_OPEN: begin
          if (key_q) begin
            err = amf0_pkg::ST_INVALID;
          end else if ((action_i == amf0_pkg::ACT_ARR_OPEN) && (value_i[63:32] != '0)) begin
            err = amf0_pkg::ST_INVALID;
          end else if (depth_sum >= (DW + 1)'(MAX_NESTING)) begin
            err = amf0_pkg::ST_INVALID;
          end else if (!room) begin
            err = amf0_pkg::ST_NO_SPACE;
          end else begin
            nkey = 1'b1;
            if (action_i == amf0_pkg::ACT_OBJ_OPEN) begin
              n     = 4'd1;
              bytes = {amf0_pkg::TAG_OBJECT, 64'd0};
              nobj  = obj_q + DW'(1);
            end else begin
              n     = 4'd5;
              bytes = {amf0_pkg::TAG_ECMA_ARRAY, value_i[31:0], 32'd0};
              narr  = arr_q + DW'(1);
            end
          end
        end
        amf0_pkg::ACT_OBJ_CLOSE, amf0_pkg::ACT_ARR_CLOSE: begin
          if (!key_q) begin
            err = amf0_pkg::ST_INVALID;
          end else if ((action_i == amf0_pkg::ACT_OBJ_CLOSE) ? (obj_q == '0)
                                                             : (arr_q == '0)) begin
            err = amf0_pkg::ST_INVALID;
          end else if (!room) begin
            err = amf0_pkg::ST_NO_SPACE;
          end else begin
            n     = 4'd3;
            bytes = {8'h00, 8'h00, amf0_pkg::TAG_OBJECT_END, 48'd0};
            if (action_i == amf0_pkg::ACT_OBJ_CLOSE) begin
              nobj = obj_q - DW'(1);
              nkey = (obj_q != DW'(1)) || (arr_q != '0);
            end else begin
              narr = arr_q - DW'(1);
              nkey = (arr_q != DW'(1)) || (obj_q != '0);
            end
          end
        end
        default: err = amf0_pkg::ST_INVALID;
      endcase
    end

    if (!flag) begin
      if (err != amf0_pkg::ST_OK) begin
        flag     = 1'b1;
        flag_st  = err;
        sticky_d = err;
      end else begin
        obj_d  = nobj;
        arr_d  = narr;
        key_d  = nkey;
        body_d = nbody;
        fill_d = fill_q + 32'(n);
      end
    end

    cmd_o.n      = flag ? 4'd0 : n;
    cmd_o.bytes  = flag ? '0 : bytes;
    cmd_o.status = flag ? flag_st : amf0_pkg::ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= amf0_pkg::CAPACITY_RESET;
      start_q <= amf0_pkg::START_FILL_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == amf0_pkg::CFG_CAPACITY) begin
        cap_q <= cfg_data_i;
      end else begin
        start_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_q    <= '0;
      arr_q    <= '0;
      key_q    <= 1'b0;
      fill_q   <= amf0_pkg::START_FILL_RESET;
      sticky_q <= amf0_pkg::ST_OK;
      body_q   <= '0;
    end else if (accept_i) begin
      obj_q    <= obj_d;
      arr_q    <= arr_d;
      key_q    <= key_d;
      fill_q   <= fill_d;
      sticky_q <= sticky_d;
      body_q   <= body_d;
    end
  end

  a_sticky_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sticky_q == amf0_pkg::ST_OK) || (sticky_q == amf0_pkg::ST_INVALID) ||
    (sticky_q == amf0_pkg::ST_NO_SPACE))
    else $error("sticky error holds an unknown code");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_sum <= (DW + 1)'(MAX_NESTING))
    else $error("nesting depth beyond limit");

endmodule

`default_nettype wire

// ----- rtl/core/amf0_cmd_fifo.sv -----
// Short command queue between the front end and the byte emitter.
// Depends on amf0_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amf0_cmd_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  wire amf0_pkg::cmd_t wr_data_i,
  output logic           full_o,
  output logic           valid_o,
  output amf0_pkg::cmd_t rd_data_o,
  input  wire logic      rd_i
);

  amf0_pkg::cmd_t                   mem_q [amf0_pkg::CMD_DEPTH];
  logic [amf0_pkg::CMD_PTR_W-1:0]   wptr_q, rptr_q;
  logic [amf0_pkg::CMD_PTR_W:0]     cnt_q;
  logic                             do_wr, do_rd;

  assign full_o    = cnt_q == (amf0_pkg::CMD_PTR_W + 1)'(amf0_pkg::CMD_DEPTH);
  assign valid_o   = cnt_q != '0;
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/amf0_back.sv -----
// Byte emitter: walks each queued command and fills the result register.
// Depends on amf0_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amf0_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire amf0_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  wire logic      pop,
  output logic [7:0]     out_byte_o,
  output logic           byte_valid_o,
  output logic           last_o,
  output logic [1:0]     status_o
);

  logic [3:0] idx_q;
  logic       out_vld_q;
  logic [7:0] byte_q;
  logic       bvld_q, last_q;
  logic [1:0] st_q;
  logic       load;
  logic [7:0] sel;
  logic       at_end;

  assign load   = cmd_valid_i && (!out_vld_q || pop);
  assign at_end = (cmd_i.n == 4'd0) || (idx_q == cmd_i.n - 4'd1);
  assign cmd_pop_o = load && at_end;

  always_comb begin
    sel = '0;
    for (int k = 0; k < amf0_pkg::CMD_BYTES; k++) begin
      if (idx_q == 4'(k)) begin
        sel = cmd_i.bytes[amf0_pkg::CMD_BITS - 1 - 8 * k -: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= at_end ? 4'd0 : idx_q + 4'd1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= (cmd_i.n == 4'd0) ? 8'h00 : sel;
      bvld_q <= cmd_i.n != 4'd0;
      last_q <= at_end;
      st_q   <= cmd_i.status;
    end
  end

  assign empty        = !out_vld_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvld_q;
  assign last_o       = last_q;
  assign status_o     = st_q;

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && bvld_q) |-> (st_q == amf0_pkg::ST_OK))
    else $error("byte item carries a nonzero status");

  a_flag_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !bvld_q) |-> (last_q && (byte_q == 8'h00)))
    else $error("status-only item not marked last");

endmodule

`default_nettype wire

// ----- rtl/core/amf0_token_serializer.sv -----
// AMF0 token serializer top level: front end, command queue, byte emitter.
// Depends on amf0_pkg, amf0_front, amf0_cmd_fifo, amf0_back.
//
// Usage: tokens enter through a queue-style port (push/full with action_i,
// value_i). Each accepted token yields one or more result items on the
// output queue port (empty/pop with out_byte_o, byte_valid_o, last_o,
// status_o): one item per encoded byte, last_o on the final one, or a
// single status-only item for finish and for rejected tokens.
// Configuration (capacity, start fill) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while no token
// is in flight, as the block does not enforce this. The first item of a
// token passes the command queue, then the output register. The front end
// takes one token per cycle while full is low; the emitter moves one byte
// or status-only item per cycle while its output is free or popped. A
// four-entry queue absorbs the difference; full rises when it fills.
// Reset clears nesting, key, string and error state, loads capacity 4096
// and start fill 0. When pop stays low the output item holds and the
// queue fills, then full holds off new tokens; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module amf0_token_serializer #(
  parameter int MAX_NESTING = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [3:0]  action_i,
  input  wire logic [63:0] value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             last_o,
  output logic [1:0]       status_o
);

  amf0_pkg::cmd_t front_cmd, back_cmd;
  logic           accept;
  logic           cmd_valid, cmd_pop;

  assign accept = push && !full;

  amf0_front #(
    .MAX_NESTING (MAX_NESTING)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .action_i   (action_i),
    .value_i    (value_i),
    .cmd_o      (front_cmd)
  );

  amf0_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .valid_o   (cmd_valid),
    .rd_data_o (back_cmd),
    .rd_i      (cmd_pop)
  );

  amf0_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

// ----- bench/tb_amf0_token_serializer.sv -----
// Self-checking testbench for amf0_token_serializer: directed and random token streams,
// with random stalls on both queue ports, checked item by item against a byte predictor.
// Depends on amf0_pkg and the amf0_token_serializer RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [1:0] status;
} amf0_item_t;

class amf0_byte_predictor;
  localparam int unsigned NEST_LIMIT = 15;

  logic [31:0]  capacity;
  logic [31:0]  start_fill;
  int unsigned  obj_depth;
  int unsigned  arr_depth;
  bit           key_expected;
  logic [31:0]  fill;
  logic [1:0]   sticky;
  logic [31:0]  body_left;
  amf0_item_t   expected_bytes[$];
  int unsigned  mismatches;
  int unsigned  checked;
  int unsigned  rejects;

  function new();
    capacity   = amf0_pkg::CAPACITY_RESET;
    start_fill = amf0_pkg::START_FILL_RESET;
    mismatches = 0;
    checked    = 0;
    rejects    = 0;
    clear_message();
  endfunction

  function void clear_message();
    obj_depth    = 0;
    arr_depth    = 0;
    key_expected = 1'b0;
    fill         = start_fill;
    sticky       = amf0_pkg::ST_OK;
    body_left    = '0;
  endfunction

  function void write_config(logic [31:0] cap, logic [31:0] sf);
    capacity   = cap;
    start_fill = sf;
  endfunction

  function bit nested();
    return obj_depth != 0 || arr_depth != 0;
  endfunction

  function bit room(logic [63:0] n);
    return ({32'd0, fill} + n) <= {32'd0, capacity};
  endfunction

  function void push_flag(logic [1:0] st);
    amf0_item_t it;
    it.out_byte   = 8'h00;
    it.byte_valid = 1'b0;
    it.last       = 1'b1;
    it.status     = st;
    expected_bytes.push_back(it);
  endfunction

  function void reject(logic [1:0] code);
    sticky = code;
    rejects++;
    push_flag(code);
  endfunction

  // b holds the encoded bytes, first byte in the top bits
  function void push_bytes(logic [71:0] b, int n);
    amf0_item_t it;
    for (int k = 0; k < n; k++) begin
      it.out_byte   = b[71-8*k -: 8];
      it.byte_valid = 1'b1;
      it.last       = (k == n - 1);
      it.status     = amf0_pkg::ST_OK;
      expected_bytes.push_back(it);
    end
    fill = fill + n;
  endfunction

  function void accept_token(logic [3:0] act, logic [63:0] v);
    logic [1:0] st;
    if (act == amf0_pkg::ACT_FINISH) begin
      st = sticky;
      if (st == amf0_pkg::ST_OK && (nested() || body_left != 0)) st = amf0_pkg::ST_INVALID;
      clear_message();
      push_flag(st);
      return;
    end
    if (sticky != amf0_pkg::ST_OK) begin
      push_flag(sticky);
      return;
    end
    if (body_left != 0) begin
      if (act != amf0_pkg::ACT_STRING_BYTE) begin
        reject(amf0_pkg::ST_INVALID);
        return;
      end
      body_left = body_left - 1;
      push_bytes({v[7:0], 64'd0}, 1);
      return;
    end
    case (act)
      amf0_pkg::ACT_NUMBER: begin
        if (key_expected) reject(amf0_pkg::ST_INVALID);
        else if (!room(64'd9)) reject(amf0_pkg::ST_NO_SPACE);
        else begin
          key_expected = nested();
          push_bytes({amf0_pkg::TAG_NUMBER, v}, 9);
        end
      end
      amf0_pkg::ACT_BOOLEAN: begin
        if (key_expected) reject(amf0_pkg::ST_INVALID);
        else if (!room(64'd2)) reject(amf0_pkg::ST_NO_SPACE);
        else begin
          key_expected = nested();
          push_bytes({amf0_pkg::TAG_BOOLEAN, v[7:0], 56'd0}, 2);
        end
      end
      amf0_pkg::ACT_STRING_HDR: begin
        if (key_expected) begin
          if (v > 64'hFFFF) reject(amf0_pkg::ST_INVALID);
          else if (!room(64'd2 + v)) reject(amf0_pkg::ST_NO_SPACE);
          else begin
            key_expected = 1'b0;
            body_left    = v[31:0];
            push_bytes({v[15:0], 56'd0}, 2);
          end
        end else if (v > 64'hFFFF_FFFF) begin
          reject(amf0_pkg::ST_INVALID);
        end else if (v <= 64'hFFFF) begin
          if (!room(64'd3 + v)) reject(amf0_pkg::ST_NO_SPACE);
          else begin
            key_expected = nested();
            body_left    = v[31:0];
            push_bytes({amf0_pkg::TAG_STRING, v[15:0], 48'd0}, 3);
          end
        end else begin
          if (!room(64'd5 + v)) reject(amf0_pkg::ST_NO_SPACE);
          else begin
            key_expected = nested();
            body_left    = v[31:0];
            push_bytes({amf0_pkg::TAG_LONG_STRING, v[31:0], 32'd0}, 5);
          end
        end
      end
      amf0_pkg::ACT_OBJ_OPEN, amf0_pkg::ACT_ARR_OPEN: begin
        if (key_expected) reject(amf0_pkg::ST_INVALID);
        else if (act == amf0_pkg::ACT_ARR_OPEN && v > 64'hFFFF_FFFF)
          reject(amf0_pkg::ST_INVALID);
        else if (obj_depth + arr_depth >= NEST_LIMIT) reject(amf0_pkg::ST_INVALID);
        else if (act == amf0_pkg::ACT_OBJ_OPEN) begin
          if (!room(64'd1)) reject(amf0_pkg::ST_NO_SPACE);
          else begin
            obj_depth++;
            key_expected = 1'b1;
            push_bytes({amf0_pkg::TAG_OBJECT, 64'd0}, 1);
          end
        end else begin
          if (!room(64'd5)) reject(amf0_pkg::ST_NO_SPACE);
          else begin
            arr_depth++;
            key_expected = 1'b1;
            push_bytes({amf0_pkg::TAG_ECMA_ARRAY, v[31:0], 32'd0}, 5);
          end
        end
      end
      amf0_pkg::ACT_OBJ_CLOSE, amf0_pkg::ACT_ARR_CLOSE: begin
        if (!key_expected) reject(amf0_pkg::ST_INVALID);
        else if ((act == amf0_pkg::ACT_OBJ_CLOSE ? obj_depth : arr_depth) == 0)
          reject(amf0_pkg::ST_INVALID);
        else if (!room(64'd3)) reject(amf0_pkg::ST_NO_SPACE);
        else begin
          if (act == amf0_pkg::ACT_OBJ_CLOSE) obj_depth--;
          else arr_depth--;
          key_expected = nested();
          push_bytes({16'h0000, amf0_pkg::TAG_OBJECT_END, 48'd0}, 3);
        end
      end
      amf0_pkg::ACT_NULL: begin
        if (key_expected) reject(amf0_pkg::ST_INVALID);
        else if (!room(64'd1)) reject(amf0_pkg::ST_NO_SPACE);
        else begin
          key_expected = nested();
          push_bytes({amf0_pkg::TAG_NULL, 64'd0}, 1);
        end
      end
      default: reject(amf0_pkg::ST_INVALID);
    endcase
  endfunction

  function void check_item(amf0_item_t got);
    amf0_item_t want;
    checked++;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("item %0d unexpected: byte %h valid %b last %b status %0d",
                 checked, got.out_byte, got.byte_valid, got.last, got.status);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.last !== want.last || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("item %0d: exp byte %h valid %b last %b status %0d, got %h %b %b %0d",
                 checked, want.out_byte, want.byte_valid, want.last, want.status,
                 got.out_byte, got.byte_valid, got.last, got.status);
    end
  endfunction
endclass

module tb_amf0_token_serializer;
  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = amf0_pkg::CFG_CAPACITY;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [3:0]  action_i = amf0_pkg::ACT_NUMBER;
  logic [63:0] value_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        last_o;
  logic [1:0]  status_o;

  amf0_byte_predictor enc = new();
  amf0_item_t         rx_item;
  int unsigned        tokens_sent = 0;
  int unsigned        cycles = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  bit                 stall_rx = 1'b0;
  bit                 calm = 1'b0;

  amf0_token_serializer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .value_i      (value_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_amf0_token_serializer NOT OK");
      $finish;
    end
  end

  // output side: check on handshake, then pick the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      rx_item.out_byte   = out_byte_o;
      rx_item.byte_valid = byte_valid_o;
      rx_item.last       = last_o;
      rx_item.status     = status_o;
      enc.check_item(rx_item);
    end
    if (stall_rx && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 13);
    end
  end

  task automatic send_token(input logic [3:0] act, input logic [63:0] v);
    if (!calm && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    action_i <= act;
    value_i  <= v;
    do @(posedge clk_i); while (full);
    enc.accept_token(act, v);
    tokens_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (enc.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // finish afterwards so the new start fill takes effect
  task automatic load_config(input logic [31:0] cap, input logic [31:0] sf);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= amf0_pkg::CFG_CAPACITY;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_idx_i  <= amf0_pkg::CFG_START_FILL;
    cfg_data_i <= sf;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    enc.write_config(cap, sf);
    send_token(amf0_pkg::ACT_FINISH, '0);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 8));
      1:       return 64'h0000_FFFF + 64'($urandom_range(0, 1));
      2:       return 64'hFFFF_FFFF + 64'($urandom_range(0, 1));
      5:       return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_noise();
    logic [3:0] act;
    act = 4'($urandom_range(0, 15));
    send_token(act, pick_value());
  endtask

  task automatic send_open();
    send_token($urandom_range(0, 1) ? amf0_pkg::ACT_OBJ_OPEN : amf0_pkg::ACT_ARR_OPEN,
               64'($urandom));
  endtask

  task automatic send_close();
    if (enc.obj_depth != 0 && (enc.arr_depth == 0 || $urandom_range(0, 1)))
      send_token(amf0_pkg::ACT_OBJ_CLOSE, {$urandom, $urandom});
    else
      send_token(amf0_pkg::ACT_ARR_CLOSE, {$urandom, $urandom});
  endtask

  task automatic send_value(input bit allow_open);
    case ($urandom_range(0, allow_open ? 7 : 5))
      0, 5:    send_token(amf0_pkg::ACT_NUMBER, {$urandom, $urandom});
      1:       send_token(amf0_pkg::ACT_BOOLEAN, {$urandom, $urandom});
      2:       send_token(amf0_pkg::ACT_NULL, {$urandom, $urandom});
      3, 4:    send_token(amf0_pkg::ACT_STRING_HDR, 64'($urandom_range(0, 5)));
      6:       send_token(amf0_pkg::ACT_OBJ_OPEN, {$urandom, $urandom});
      default: send_token(amf0_pkg::ACT_ARR_OPEN, 64'($urandom));
    endcase
  endtask

  // one message: grammatical tokens with some noise, closed by finish
  task automatic run_message(input int budget, input bit dive);
    bit done;
    int tail;
    done = 1'b0;
    while (!done) begin
      if (enc.sticky != amf0_pkg::ST_OK) begin
        tail = $urandom_range(0, 2);
        repeat (tail) send_noise();
        send_token(amf0_pkg::ACT_FINISH, {$urandom, $urandom});
        done = 1'b1;
      end else if ($urandom_range(99) < 3) begin
        send_noise();
      end else if (enc.body_left > 16) begin
        send_token(amf0_pkg::ACT_FINISH, {$urandom, $urandom});
        done = 1'b1;
      end else if (enc.body_left != 0) begin
        send_token(amf0_pkg::ACT_STRING_BYTE, {$urandom, $urandom});
      end else if (enc.key_expected) begin
        if (!dive && (budget <= 0 || $urandom_range(99) < 30)) send_close();
        else send_token(amf0_pkg::ACT_STRING_HDR, 64'($urandom_range(0, 3)));
      end else if (dive) begin
        send_open();
      end else if (!enc.nested() && budget <= 0) begin
        send_token(amf0_pkg::ACT_FINISH, {$urandom, $urandom});
        done = 1'b1;
      end else begin
        send_value(budget > 0);
      end
      budget--;
    end
  endtask

  task automatic run_random(input int count);
    int unsigned target;
    target = tokens_sent + count;
    while (tokens_sent < target)
      run_message($urandom_range(1, 12), $urandom_range(99) < 8);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_token(amf0_pkg::ACT_NUMBER, 64'hFFFF_FFFF_FFFF_FFFF);
    send_token(amf0_pkg::ACT_BOOLEAN, 64'hFFFF_FFFF_FFFF_FF00);
    send_token(amf0_pkg::ACT_NULL, '0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd2);
    send_token(amf0_pkg::ACT_STRING_BYTE, 64'hFF);
    send_token(amf0_pkg::ACT_NUMBER, '0);                      // body cut short
    send_token(amf0_pkg::ACT_NULL, '0);                        // error already latched
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd70000);           // no room at 4096
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_STRING_BYTE, 64'h5A);             // no body open
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(4'hF, '0);
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_OBJ_OPEN, '0);
    send_token(amf0_pkg::ACT_NULL, '0);                        // value where a key belongs
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_OBJ_OPEN, '0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd0);
    send_token(amf0_pkg::ACT_OBJ_CLOSE, '0);                   // key without value
    send_token(amf0_pkg::ACT_ARR_CLOSE, '0);
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_OBJ_OPEN, '0);
    send_token(amf0_pkg::ACT_ARR_CLOSE, '0);                   // kind never opened
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_OBJ_OPEN, '0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd65536);           // key too long
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_ARR_OPEN, 64'hFFFF_FFFF);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd1);
    send_token(amf0_pkg::ACT_STRING_BYTE, 64'h00);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd0);
    send_token(amf0_pkg::ACT_ARR_CLOSE, '0);
    send_token(amf0_pkg::ACT_OBJ_OPEN, '0);
    send_token(amf0_pkg::ACT_FINISH, '0);                      // object left open

    stall_rx = 1'b1;
    run_random(50);
    calm = 1'b1;
    run_random(40);
    calm = 1'b0;
    run_random(30);

    load_config(32'd0, 32'd0);
    run_random(15);
    load_config(32'd60, 32'd0);
    run_random(35);

    load_config(32'hFFFF_FFFF, 32'd0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'd70000);           // long string tag
    send_token(amf0_pkg::ACT_STRING_BYTE, 64'h3C);
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_STRING_HDR, 64'h1_0000_0000);
    send_token(amf0_pkg::ACT_FINISH, '0);
    send_token(amf0_pkg::ACT_ARR_OPEN, 64'h1_0000_0000);
    send_token(amf0_pkg::ACT_FINISH, '0);
    run_random(35);

    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(10);
    load_config($urandom_range(300, 3000), $urandom_range(0, 200));
    run_random(40);

    settle();
    repeat (20) @(posedge clk_i);
    $display("%0d tokens sent over six buffer settings, %0d output items checked",
             tokens_sent, enc.checked);
    $display("%0d tokens rejected, %0d mismatches", enc.rejects, enc.mismatches);
    if (enc.mismatches == 0 && enc.expected_bytes.size() == 0) begin
      $display("tb_amf0_token_serializer OK");
    end else begin
      $display("tb_amf0_token_serializer NOT OK");
    end
    $finish;
  end
endmodule
